// ===== src/circular_doubly_linked_list_core_macros.svh =====
// Assertion macros for the checker file of the linked list core.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_CORE_MACROS_SVH

// Checked only while reset is released.
`define CDLL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CDLL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cdll_pkg.sv =====
// Types and constants shared by the linked list core modules.
`default_nettype none
package cdll_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP        = 3'd3,
        OP_DELETE     = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_A,
        S_PUSH_B,
        S_WALK,
        S_INS_B,
        S_FINISH
    } state_t;

    // Requests from the sequencer to the slot allocator.
    typedef struct packed {
        logic take;
        logic give;
    } alloc_ctl_t;

endpackage
`default_nettype wire

// ===== src/circular_doubly_linked_list_core.sv =====
// Steps: insert, pop, delete or search on an empty list, a push to a full pool or an unused
// code goes straight to the result register. A push writes the value, then the links in
// S_PUSH_A and, unless the list was empty, S_PUSH_B. Insert, pop, delete and search walk
// the list node by node in S_WALK; an insert that adds a node also passes S_INS_B.
// One request at a time, taken only after the last result is registered; a stall delays that.
// Reset: asynchronous, active low; the list is empty and all slots are free at once.
`default_nettype none
module circular_doubly_linked_list_core #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // [31:0] value, [63:32] new_value
    input  wire logic [2:0]  s_tuser,  // [2:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata   // [1:0] status, [7:2] count
);

    localparam int SW = $clog2(CAPACITY);

    cdll_pkg::alloc_ctl_t alloc_ctl;
    logic          any_free;
    logic [SW-1:0] low_slot;
    logic [SW-1:0] give_slot;
    logic [SW-1:0] raddr;
    logic [cdll_pkg::VALUE_W-1:0] val_rdata;
    logic [SW-1:0] next_rdata;
    logic [SW-1:0] prev_rdata;
    logic          val_we, next_we, prev_we;
    logic [SW-1:0] val_waddr, next_waddr, prev_waddr;
    logic [cdll_pkg::VALUE_W-1:0] val_wdata;
    logic [SW-1:0] next_wdata, prev_wdata;
    logic [cdll_pkg::STATUS_W-1:0]    out_status;
    logic [cdll_pkg::COUNT_OUT_W-1:0] out_count;

    cdll_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_tvalid && s_tready),
        .in_op       (cdll_pkg::op_t'(s_tuser)),
        .in_value    (s_tdata[31:0]),
        .in_new_value(s_tdata[63:32]),
        .ready       (s_tready),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_count   (out_count),
        .any_free    (any_free),
        .low_slot    (low_slot),
        .alloc_ctl   (alloc_ctl),
        .give_slot   (give_slot),
        .raddr       (raddr),
        .val_rdata   (val_rdata),
        .next_rdata  (next_rdata),
        .prev_rdata  (prev_rdata),
        .val_we      (val_we),
        .val_waddr   (val_waddr),
        .val_wdata   (val_wdata),
        .next_we     (next_we),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .prev_we     (prev_we),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata)
    );

    cdll_alloc #(
        .CAPACITY(CAPACITY)
    ) u_alloc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (alloc_ctl),
        .give_slot(give_slot),
        .any_free (any_free),
        .low_slot (low_slot)
    );

    cdll_ram #(
        .WIDTH(cdll_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_val_ram (
        .clk  (clk),
        .we   (val_we),
        .waddr(val_waddr),
        .wdata(val_wdata),
        .raddr(raddr),
        .rdata(val_rdata)
    );

    cdll_ram #(
        .WIDTH(SW),
        .DEPTH(CAPACITY)
    ) u_next_ram (
        .clk  (clk),
        .we   (next_we),
        .waddr(next_waddr),
        .wdata(next_wdata),
        .raddr(raddr),
        .rdata(next_rdata)
    );

    cdll_ram #(
        .WIDTH(SW),
        .DEPTH(CAPACITY)
    ) u_prev_ram (
        .clk  (clk),
        .we   (prev_we),
        .waddr(prev_waddr),
        .wdata(prev_wdata),
        .raddr(raddr),
        .rdata(prev_rdata)
    );

    assign m_tdata = {out_count, out_status};

endmodule
`default_nettype wire

// ===== src/cdll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/cdll_alloc.sv =====
// Free slot map with a lowest-free-slot encoder.
`default_nettype none
module cdll_alloc #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cdll_pkg::alloc_ctl_t        ctl,
    input  wire logic [$clog2(CAPACITY)-1:0] give_slot,
    output logic                             any_free,
    output logic      [$clog2(CAPACITY)-1:0] low_slot
);

    localparam int SW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] free_reg;
    logic [CAPACITY-1:0] free_next;

    always_comb
    begin
        any_free = |free_reg;
        low_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                low_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (ctl.take)
        begin
            free_next[low_slot] = 1'b0;
        end
        if (ctl.give)
        begin
            free_next[give_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/cdll_seq.sv =====
// Operation sequencer: list walk with the shared key compare, link updates, result register.
`default_nettype none
module cdll_seq #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire cdll_pkg::op_t                        in_op,
    input  wire logic [cdll_pkg::VALUE_W-1:0]         in_value,
    input  wire logic [cdll_pkg::VALUE_W-1:0]         in_new_value,
    output logic                                      ready,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic      [cdll_pkg::STATUS_W-1:0]        out_status,
    output logic      [cdll_pkg::COUNT_OUT_W-1:0]     out_count,
    input  wire logic                                 any_free,
    input  wire logic [$clog2(CAPACITY)-1:0]          low_slot,
    output cdll_pkg::alloc_ctl_t                      alloc_ctl,
    output logic      [$clog2(CAPACITY)-1:0]          give_slot,
    output logic      [$clog2(CAPACITY)-1:0]          raddr,
    input  wire logic [cdll_pkg::VALUE_W-1:0]         val_rdata,
    input  wire logic [$clog2(CAPACITY)-1:0]          next_rdata,
    input  wire logic [$clog2(CAPACITY)-1:0]          prev_rdata,
    output logic                                      val_we,
    output logic      [$clog2(CAPACITY)-1:0]          val_waddr,
    output logic      [cdll_pkg::VALUE_W-1:0]         val_wdata,
    output logic                                      next_we,
    output logic      [$clog2(CAPACITY)-1:0]          next_waddr,
    output logic      [$clog2(CAPACITY)-1:0]          next_wdata,
    output logic                                      prev_we,
    output logic      [$clog2(CAPACITY)-1:0]          prev_waddr,
    output logic      [$clog2(CAPACITY)-1:0]          prev_wdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    cdll_pkg::state_t  state_reg, state_next;
    cdll_pkg::op_t     op_reg, op_next;
    cdll_pkg::status_t status_reg, status_next;
    logic [cdll_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [cdll_pkg::VALUE_W-1:0] nval_reg, nval_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [cdll_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [cdll_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic          hit;

    // The key comparator of the block; pop front matches the head node outright.
    assign hit = (op_reg == cdll_pkg::OP_POP) || (val_rdata == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        key_next        = key_reg;
        nval_next       = nval_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ready           = 1'b0;
        alloc_ctl       = '0;
        give_slot       = cur_reg;
        raddr           = head_reg;
        val_we          = 1'b0;
        val_waddr       = slot_reg;
        val_wdata       = nval_reg;
        next_we         = 1'b0;
        next_waddr      = slot_reg;
        next_wdata      = slot_reg;
        prev_we         = 1'b0;
        prev_waddr      = slot_reg;
        prev_wdata      = slot_reg;

        unique case (state_reg)
            cdll_pkg::S_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    op_next     = in_op;
                    key_next    = in_value;
                    nval_next   = in_new_value;
                    status_next = cdll_pkg::STAT_OK;
                    unique case (in_op) inside
                        cdll_pkg::OP_PUSH_FRONT, cdll_pkg::OP_PUSH_BACK:
                        begin
                            if (!any_free)
                            begin
                                status_next = cdll_pkg::STAT_FULL;
                                state_next  = cdll_pkg::S_FINISH;
                            end
                            else
                            begin
                                alloc_ctl.take = 1'b1;
                                slot_next      = low_slot;
                                val_we         = 1'b1;
                                val_waddr      = low_slot;
                                val_wdata      = in_value;
                                state_next     = cdll_pkg::S_PUSH_A;
                            end
                        end
                        cdll_pkg::OP_INSERT, cdll_pkg::OP_POP,
                        cdll_pkg::OP_DELETE, cdll_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = cdll_pkg::STAT_EMPTY;
                                state_next  = cdll_pkg::S_FINISH;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                cur_next   = head_reg;
                                idx_next   = '0;
                                state_next = cdll_pkg::S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = cdll_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            cdll_pkg::S_PUSH_A:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                count_next = count_reg + CW'(1);
                if (count_reg == '0)
                begin
                    next_wdata = slot_reg;
                    prev_wdata = slot_reg;
                    head_next  = slot_reg;
                    tail_next  = slot_reg;
                    state_next = cdll_pkg::S_FINISH;
                end
                else
                begin
                    next_wdata = head_reg;
                    prev_wdata = tail_reg;
                    state_next = cdll_pkg::S_PUSH_B;
                end
            end

            cdll_pkg::S_PUSH_B:
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                next_wdata = slot_reg;
                prev_we    = 1'b1;
                prev_waddr = head_reg;
                prev_wdata = slot_reg;
                if (op_reg == cdll_pkg::OP_PUSH_FRONT)
                begin
                    head_next = slot_reg;
                end
                else
                begin
                    tail_next = slot_reg;
                end
                state_next = cdll_pkg::S_FINISH;
            end

            cdll_pkg::S_WALK:
            begin
                // The next link of the node just read addresses the following read.
                raddr = next_rdata;
                if (hit)
                begin
                    state_next = cdll_pkg::S_FINISH;
                    unique case (op_reg) inside
                        cdll_pkg::OP_INSERT:
                        begin
                            if (!any_free)
                            begin
                                status_next = cdll_pkg::STAT_FULL;
                            end
                            else
                            begin
                                // Reading the key node again puts its successor on the
                                // next-link read port for the second write.
                                raddr          = cur_reg;
                                alloc_ctl.take = 1'b1;
                                slot_next      = low_slot;
                                val_we         = 1'b1;
                                val_waddr      = low_slot;
                                val_wdata      = nval_reg;
                                next_we        = 1'b1;
                                next_waddr     = low_slot;
                                next_wdata     = next_rdata;
                                prev_we        = 1'b1;
                                prev_waddr     = low_slot;
                                prev_wdata     = cur_reg;
                                state_next     = cdll_pkg::S_INS_B;
                            end
                        end
                        cdll_pkg::OP_POP, cdll_pkg::OP_DELETE:
                        begin
                            alloc_ctl.give = 1'b1;
                            give_slot      = cur_reg;
                            count_next     = count_reg - CW'(1);
                            if (count_reg <= CW'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                next_we    = 1'b1;
                                next_waddr = prev_rdata;
                                next_wdata = next_rdata;
                                prev_we    = 1'b1;
                                prev_waddr = next_rdata;
                                prev_wdata = prev_rdata;
                                if (cur_reg == head_reg)
                                begin
                                    head_next = next_rdata;
                                end
                                if (cur_reg == tail_reg)
                                begin
                                    tail_next = prev_rdata;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = cdll_pkg::STAT_OK;
                        end
                    endcase
                end
                else if ((idx_reg + CW'(1)) == count_reg)
                begin
                    status_next = cdll_pkg::STAT_MISSING;
                    state_next  = cdll_pkg::S_FINISH;
                end
                else
                begin
                    cur_next = next_rdata;
                    idx_next = idx_reg + CW'(1);
                end
            end

            cdll_pkg::S_INS_B:
            begin
                // Successor of the key node is still on the next-link read port.
                raddr      = cur_reg;
                prev_we    = 1'b1;
                prev_waddr = next_rdata;
                prev_wdata = slot_reg;
                next_we    = 1'b1;
                next_waddr = cur_reg;
                next_wdata = slot_reg;
                if (cur_reg == tail_reg)
                begin
                    tail_next = slot_reg;
                end
                count_next = count_reg + CW'(1);
                state_next = cdll_pkg::S_FINISH;
            end

            cdll_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = cdll_pkg::COUNT_OUT_W'(count_reg);
                    state_next      = cdll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cdll_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdll_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        key_reg        <= key_next;
        nval_reg       <= nval_next;
        cur_reg        <= cur_next;
        slot_reg       <= slot_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule
`default_nettype wire

// ===== src/cdll_checker.sv =====
// Port-level checker for the linked list core, bound to the top level.
`default_nettype none
`include "circular_doubly_linked_list_core_macros.svh"
module cdll_checker #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    localparam logic [cdll_pkg::COUNT_OUT_W-1:0] FULL_COUNT =
        cdll_pkg::COUNT_OUT_W'(CAPACITY);

    logic       req_taken;
    logic       res_wait;
    logic [8:0] res_bus;
    logic       full_res;
    logic       full_ok;
    logic       empty_res;
    logic       empty_ok;

    assign req_taken = s_tvalid && s_tready;
    assign res_wait  = m_tvalid && !m_tready;
    assign res_bus   = {m_tvalid, m_tdata};
    assign full_res  = m_tvalid && (m_tdata[1:0] == cdll_pkg::STAT_FULL);
    assign full_ok   = (m_tdata[7:2] == FULL_COUNT);
    assign empty_res = m_tvalid && (m_tdata[1:0] == cdll_pkg::STAT_EMPTY);
    assign empty_ok  = (m_tdata[7:2] == '0);

    `CDLL_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !m_tvalid, "result during reset")

    `CDLL_ASSERT(a_result_holds, clk, rst_n, res_wait |=> $stable(res_bus), "stalled result moved")

    `CDLL_ASSERT(a_busy_after_req, clk, rst_n, req_taken |=> !s_tready, "request taken while busy")

    `CDLL_ASSERT(a_full_at_capacity, clk, rst_n, full_res |-> full_ok, "pool full below capacity")

    `CDLL_ASSERT(a_empty_at_zero, clk, rst_n, empty_res |-> empty_ok, "list empty with nodes")

endmodule

bind circular_doubly_linked_list_core cdll_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
`default_nettype wire
